// File: src/ptwa_pkg.sv
// ----------------------------------------------------------------------------
// ptwa_pkg
// Shared types, codes and helpers for the peer table with aging.
// ----------------------------------------------------------------------------
package ptwa_pkg;

  // Table geometry and field widths
  localparam int unsigned DEF_MAX_PEERS = 16;
  localparam int unsigned ID_W          = 32;
  localparam int unsigned TIME_W        = 32;
  localparam int unsigned COUNT_W       = 5;
  localparam int unsigned COUNT_MAX     = 31;

  // Configuration register map
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned CFG_DAT_W = 32;
  localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_LOCAL_ID = 1'b1;

  localparam logic [TIME_W-1:0] TIMEOUT_RST  = 32'd5000;
  localparam logic [ID_W-1:0]   LOCAL_ID_RST = 32'd0;

  // Operation codes
  typedef enum logic [1:0] {
    OP_HEARD  = 2'd0,
    OP_SWEEP  = 2'd1,
    OP_REMOVE = 2'd2,
    OP_LOOKUP = 2'd3
  } op_e;

  // Clamp a count to the result field width
  function automatic logic [COUNT_W-1:0] sat_count(input logic [31:0] n);
    logic [COUNT_W-1:0] r;
    if (n > COUNT_MAX) begin
      r = COUNT_W'(COUNT_MAX);
    end else begin
      r = n[COUNT_W-1:0];
    end
    return r;
  endfunction

endpackage

// File: src/peer_table_with_aging.sv
// ----------------------------------------------------------------------------
// peer_table_with_aging
// Bounded peer table with last-heard timestamps, insert, refresh, remove,
// lookup and timeout sweep, walked entry by entry by a small sequencer.
// ----------------------------------------------------------------------------
// An operation is one transaction on the input channel and yields exactly one
// transaction on the output channel. After a transaction is taken the block
// raises in_stall_o and walks the whole table through a single read port of
// the id/timestamp memory, one entry per cycle, with one shared compare stage
// behind the registered read data, and takes the next transaction only once
// it is back in idle (a heard event carrying the local node ID skips the walk
// and goes straight to the commit step). The walk length is set by that single
// memory read port. The result sits in an output register, so the next
// transaction is accepted while an earlier result still waits to be taken;
// only the final commit step waits for the output register to drain. Writes
// to the table (refresh or insert) land in that commit step. The table is
// empty after reset: valid bits live in flip-flops and are cleared at once,
// so no clearing pass is needed. Configuration writes go through cfg_we_i and
// are expected only while the block is idle.
// ----------------------------------------------------------------------------
module peer_table_with_aging #(
  parameter int unsigned MAX_PEERS = ptwa_pkg::DEF_MAX_PEERS
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // configuration write port
  input  logic                           cfg_we_i,
  input  logic [ptwa_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [ptwa_pkg::CFG_DAT_W-1:0] cfg_data_i,
  // input channel
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [1:0]                     op_i,
  input  logic [ptwa_pkg::ID_W-1:0]      node_id_i,
  input  logic [ptwa_pkg::TIME_W-1:0]    now_ms_i,
  // output channel
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic                           is_new_o,
  output logic                           found_o,
  output logic [ptwa_pkg::TIME_W-1:0]    last_heard_o,
  output logic                           ignored_self_o,
  output logic                           table_full_o,
  output logic [ptwa_pkg::COUNT_W-1:0]   expired_count_o,
  output logic [ptwa_pkg::COUNT_W-1:0]   entry_count_o
);

  localparam int unsigned IDX_W = (MAX_PEERS > 1) ? $clog2(MAX_PEERS) : 1;
  localparam int unsigned CNT_W = $clog2(MAX_PEERS + 1);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_PEERS - 1);

  // Sequencer codes
  localparam logic [1:0] ST_IDLE   = 2'd0;  // wait for a transaction
  localparam logic [1:0] ST_WALK   = 2'd1;  // issue reads, compare previous entry
  localparam logic [1:0] ST_LAST   = 2'd2;  // compare the final entry
  localparam logic [1:0] ST_FINISH = 2'd3;  // commit writes, load the result

  // Configuration registers
  logic [ptwa_pkg::TIME_W-1:0] timeout_q;
  logic [ptwa_pkg::ID_W-1:0]   local_id_q;

  // Sequencer and walk state
  logic [1:0]       state_q, state_d;
  logic [IDX_W-1:0] scan_q, scan_d;
  logic             cmp_vld_q;
  logic [IDX_W-1:0] cmp_idx_q;

  // Latched operation
  logic [1:0]                  op_q;
  logic [ptwa_pkg::ID_W-1:0]   id_q;
  logic [ptwa_pkg::TIME_W-1:0] now_q;
  logic                        self_q, self_d;

  // Walk findings
  logic                        hit_q, hit_d;
  logic [IDX_W-1:0]            hit_idx_q;
  logic [ptwa_pkg::TIME_W-1:0] hit_time_q;
  logic                        free_fnd_q, free_fnd_d;
  logic [IDX_W-1:0]            free_idx_q;
  logic [CNT_W-1:0]            exp_q, exp_d;

  // Table state
  logic [MAX_PEERS-1:0]        valid_q, valid_d;
  logic [CNT_W-1:0]            count_q, count_d;
  logic [ptwa_pkg::ID_W-1:0]   ids_mem   [MAX_PEERS];
  logic [ptwa_pkg::TIME_W-1:0] times_mem [MAX_PEERS];
  logic [ptwa_pkg::ID_W-1:0]   id_rd_q;
  logic [ptwa_pkg::TIME_W-1:0] time_rd_q;

  // Output register
  logic                         out_valid_q;
  logic                         is_new_q, found_q, self_out_q, full_q;
  logic [ptwa_pkg::TIME_W-1:0]  last_q;
  logic [ptwa_pkg::COUNT_W-1:0] exp_out_q, cnt_out_q;

  // Datapath signals
  logic                        in_fire, out_free, fin_fire;
  logic                        cur_valid, id_match, first_hit, first_free;
  logic [ptwa_pkg::TIME_W-1:0] age;
  logic                        aged, clr_en;
  logic                        heard_live, ins_en, wr_en;
  logic [IDX_W-1:0]            wr_addr;
  logic                        res_is_new, res_found, res_full;
  logic [ptwa_pkg::TIME_W-1:0] res_last;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_fire    = in_valid_i && (state_q == ST_IDLE);
  assign out_free   = !out_valid_q || !out_stall_i;
  assign fin_fire   = (state_q == ST_FINISH) && out_free;

  // Shared compare stage: one entry per cycle behind the registered read
  assign cur_valid  = valid_q[cmp_idx_q];
  assign id_match   = cur_valid && (id_rd_q == id_q);
  assign first_hit  = cmp_vld_q && id_match && !hit_q;
  assign first_free = cmp_vld_q && !cur_valid && !free_fnd_q;
  assign age        = now_q - time_rd_q;
  assign aged       = cmp_vld_q && cur_valid && (age > timeout_q);
  assign clr_en     = ((op_q == ptwa_pkg::OP_SWEEP) && aged) ||
                      ((op_q == ptwa_pkg::OP_REMOVE) && first_hit);

  // Commit of a heard event: refresh the hit or fill the lowest free slot
  assign heard_live = (op_q == ptwa_pkg::OP_HEARD) && !self_q;
  assign ins_en     = fin_fire && heard_live && !hit_q && free_fnd_q;
  assign wr_en      = fin_fire && heard_live && (hit_q || free_fnd_q);
  assign wr_addr    = hit_q ? hit_idx_q : free_idx_q;

  // Result fields
  assign res_is_new = heard_live && !hit_q && free_fnd_q;
  assign res_full   = heard_live && !hit_q && !free_fnd_q;
  assign res_found  = (op_q != ptwa_pkg::OP_SWEEP) && hit_q;
  assign res_last   = ((op_q == ptwa_pkg::OP_LOOKUP) && hit_q) ? hit_time_q : '0;

  always_comb begin
    state_d    = state_q;
    scan_d     = scan_q;
    self_d     = self_q;
    hit_d      = hit_q;
    free_fnd_d = free_fnd_q;
    exp_d      = exp_q;
    valid_d    = valid_q;
    count_d    = count_q;

    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          scan_d     = '0;
          hit_d      = 1'b0;
          free_fnd_d = 1'b0;
          exp_d      = '0;
          self_d     = (op_i == ptwa_pkg::OP_HEARD) && (node_id_i == local_id_q);
          state_d    = self_d ? ST_FINISH : ST_WALK;
        end
      end
      ST_WALK: begin
        // advance the read address; the last issue hands over to ST_LAST
        if (scan_q == LAST_IDX) begin
          state_d = ST_LAST;
        end else begin
          scan_d = scan_q + IDX_W'(1);
        end
      end
      ST_LAST: begin
        state_d = ST_FINISH;
      end
      ST_FINISH: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    if (first_hit) begin
      hit_d = 1'b1;
    end
    if (first_free) begin
      free_fnd_d = 1'b1;
    end
    if (clr_en) begin
      valid_d[cmp_idx_q] = 1'b0;
      count_d            = count_d - CNT_W'(1);
    end
    if ((op_q == ptwa_pkg::OP_SWEEP) && aged) begin
      exp_d = exp_q + CNT_W'(1);
    end
    if (ins_en) begin
      valid_d[free_idx_q] = 1'b1;
      count_d             = count_d + CNT_W'(1);
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      scan_q      <= '0;
      cmp_vld_q   <= 1'b0;
      cmp_idx_q   <= '0;
      self_q      <= 1'b0;
      hit_q       <= 1'b0;
      free_fnd_q  <= 1'b0;
      exp_q       <= '0;
      valid_q     <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
      timeout_q   <= ptwa_pkg::TIMEOUT_RST;
      local_id_q  <= ptwa_pkg::LOCAL_ID_RST;
    end else begin
      state_q    <= state_d;
      scan_q     <= scan_d;
      cmp_vld_q  <= (state_q == ST_WALK);
      cmp_idx_q  <= scan_q;
      self_q     <= self_d;
      hit_q      <= hit_d;
      free_fnd_q <= free_fnd_d;
      exp_q      <= exp_d;
      valid_q    <= valid_d;
      count_q    <= count_d;
      if (fin_fire) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          ptwa_pkg::REG_TIMEOUT:  timeout_q  <= cfg_data_i;
          ptwa_pkg::REG_LOCAL_ID: local_id_q <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      op_q  <= op_i;
      id_q  <= node_id_i;
      now_q <= now_ms_i;
    end
    if (first_hit) begin
      hit_idx_q  <= cmp_idx_q;
      hit_time_q <= time_rd_q;
    end
    if (first_free) begin
      free_idx_q <= cmp_idx_q;
    end
    if (fin_fire) begin
      is_new_q   <= res_is_new;
      found_q    <= res_found;
      last_q     <= res_last;
      self_out_q <= self_q;
      full_q     <= res_full;
      exp_out_q  <= ptwa_pkg::sat_count(32'(exp_q));
      cnt_out_q  <= ptwa_pkg::sat_count(32'(count_d));
    end
  end

  // Id and timestamp memory: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    id_rd_q   <= ids_mem[scan_q];
    time_rd_q <= times_mem[scan_q];
    if (wr_en) begin
      ids_mem[wr_addr]   <= id_q;
      times_mem[wr_addr] <= now_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign is_new_o        = is_new_q;
  assign found_o         = found_q;
  assign last_heard_o    = last_q;
  assign ignored_self_o  = self_out_q;
  assign table_full_o    = full_q;
  assign expired_count_o = exp_out_q;
  assign entry_count_o   = cnt_out_q;

  // Entry count tracks the valid bits
  a_count_matches : assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(count_q) == $countones(valid_q))
    else $error("entry count differs from number of valid bits");

  // Count never exceeds capacity
  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(count_q) <= MAX_PEERS)
    else $error("entry count exceeds capacity");

  // An insert and a full flag never come together
  a_new_vs_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(is_new_o && table_full_o))
    else $error("is_new and table_full both set");

  // A self event reports nothing else
  a_self_clean : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && ignored_self_o) |-> (!found_o && !is_new_o && !table_full_o))
    else $error("self event reported other flags");

  // A refresh or insert write only comes from a walk that did not see a
  // table-changing clear in the same cycle
  a_write_exclusive : assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en |-> !clr_en)
    else $error("table write collides with a clear");

endmodule
